[src/lks_pkg.sv]
package lks_pkg;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int HB_W = 12;
	localparam int LIMIT_W = 8;
	localparam int WAIT_W = 13;
	localparam int COST_W = 32;

	localparam logic [HB_W-1:0] HB_RESET = 12'd10;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd3;

	typedef enum logic [2:0] {
		CMD_START = 3'd0,
		CMD_TICK = 3'd1,
		CMD_CONNECTED = 3'd2,
		CMD_DISCONNECTED = 3'd3,
		CMD_ERROR = 3'd4,
		CMD_SOCKET = 3'd5,
		CMD_PONG = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		LINK_READY = 2'd0,
		LINK_CONNECTING = 2'd1,
		LINK_CONNECTED = 2'd2,
		LINK_DOWN = 2'd3
	} link_mode_t;

	typedef enum logic [1:0] {
		SOCK_UNCONNECTED = 2'd0,
		SOCK_CONNECTING = 2'd1,
		SOCK_CONNECTED = 2'd2,
		SOCK_OTHER = 2'd3
	} sock_state_t;

	typedef enum logic [0:0] {
		REG_HEARTBEAT = 1'b0,
		REG_LIMIT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [HB_W-1:0] heartbeat;
		logic [LIMIT_W-1:0] limit;
	} cfg_t;

endpackage

[src/lks_regs.sv]
module lks_regs (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [lks_pkg::ADDR_W-1:0] paddr,
	input logic [lks_pkg::DATA_W-1:0] pwdata,
	output logic [lks_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output lks_pkg::cfg_t cfg
);
	import lks_pkg::*;

	logic [HB_W-1:0] heartbeat_q;
	logic [LIMIT_W-1:0] limit_q;
	logic wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heartbeat_q <= HB_RESET;
			limit_q <= LIMIT_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_HEARTBEAT: heartbeat_q <= pwdata[HB_W-1:0];
				REG_LIMIT: limit_q <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_HEARTBEAT: prdata = DATA_W'(heartbeat_q);
			REG_LIMIT: prdata = DATA_W'(limit_q);
			default: prdata = '0;
		endcase
	end

	assign cfg.heartbeat = heartbeat_q;
	assign cfg.limit = limit_q;

endmodule

[src/link_keepalive_reconnect_supervisor.sv]
// path: an accepted request passes through the input register, then the result
// register
// throughput: one request per cycle while results are taken; a stalled result takes one
// more request into the input register, then in_ready drops until the result is taken
// reset: asynchronous, active low; link ready, counters and timestamps cleared,
// ticks halted until a start request, heartbeat 10 s, reconnect limit 3
module link_keepalive_reconnect_supervisor #(
	parameter int TIME_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [lks_pkg::ADDR_W-1:0] paddr,
	input logic [lks_pkg::DATA_W-1:0] pwdata,
	output logic [lks_pkg::DATA_W-1:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_ready,
	input logic [2:0] cmd,
	input logic [31:0] now_seconds,
	input logic [1:0] socket_state,
	input logic [7:0] error_code,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] link_state,
	output logic reopen_link,
	output logic send_ping,
	output logic gave_up,
	output logic opened_notice,
	output logic closed_notice,
	output logic error_notice,
	output logic [7:0] error_out,
	output logic state_changed,
	output logic signed [31:0] ping_cost
);
	import lks_pkg::*;

	localparam int MW = (TIME_BITS > COST_W) ? TIME_BITS : COST_W;

	cfg_t cfg;

	lks_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	// input register
	logic valid_s1;
	logic [2:0] cmd_s1;
	logic [31:0] now_s1;
	logic [1:0] sock_s1;
	logic [7:0] err_s1;
	logic advance;

	assign advance = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd;
			now_s1 <= now_seconds;
			sock_s1 <= socket_state;
			err_s1 <= error_code;
		end
	end

	// supervisor state
	link_mode_t mode_q, mode_d;
	logic [WAIT_W-1:0] wait_q, wait_d;
	logic [LIMIT_W-1:0] count_q, count_d;
	logic [TIME_BITS-1:0] ping_q, ping_d;
	logic [TIME_BITS-1:0] pong_q, pong_d;
	logic halted_q, halted_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= LINK_READY;
			wait_q <= '0;
			count_q <= '0;
			ping_q <= '0;
			pong_q <= '0;
			halted_q <= 1'b1;
		end else if (advance) begin
			mode_q <= mode_d;
			wait_q <= wait_d;
			count_q <= count_d;
			ping_q <= ping_d;
			pong_q <= pong_d;
			halted_q <= halted_d;
		end
	end

	cmd_t cmd_c;
	sock_state_t sock_c;
	logic [TIME_BITS-1:0] now_t;
	logic [WAIT_W:0] wait_sum;
	logic wait_done;
	logic pong_ge;
	logic [TIME_BITS-1:0] mag;
	logic [MW-1:0] mag_w;
	logic ping_bad;
	logic [COST_W-1:0] cost_val;
	link_mode_t mode_mid;
	logic reopen_zone;
	logic limit_hit;

	assign cmd_c = cmd_t'(cmd_s1);
	assign sock_c = sock_state_t'(sock_s1);
	assign now_t = TIME_BITS'(now_s1);

	assign wait_sum = {1'b0, wait_q} + (WAIT_W + 1)'(cfg.heartbeat);
	assign wait_done = wait_sum >= {1'b0, cfg.heartbeat, 1'b0};

	assign pong_ge = pong_q >= ping_q;
	assign mag = pong_ge ? (pong_q - ping_q) : (ping_q - pong_q);
	assign mag_w = MW'(mag);
	assign ping_bad = !pong_ge || (mag > TIME_BITS'(cfg.heartbeat));
	assign cost_val = pong_ge
		? ((mag_w > MW'(32'h7fff_ffff)) ? 32'h7fff_ffff : mag_w[COST_W-1:0])
		: ((mag_w >= MW'(32'h8000_0000)) ? 32'h8000_0000 : (32'd0 - mag_w[COST_W-1:0]));

	// link mode after the connect timeout and ping check of a tick
	always_comb begin
		mode_mid = mode_q;
		if (mode_q == LINK_CONNECTING && wait_done) begin
			mode_mid = LINK_DOWN;
		end else if (mode_q == LINK_CONNECTED && ping_bad) begin
			mode_mid = LINK_DOWN;
		end
	end

	assign reopen_zone = (mode_mid == LINK_READY) || (mode_mid == LINK_DOWN);
	assign limit_hit = count_q >= cfg.limit;

	// next state
	always_comb begin
		mode_d = mode_q;
		wait_d = wait_q;
		count_d = count_q;
		ping_d = ping_q;
		pong_d = pong_q;
		halted_d = halted_q;
		case (cmd_c)
			CMD_START: begin
				mode_d = LINK_READY;
				count_d = '0;
				ping_d = '0;
				pong_d = '0;
				halted_d = 1'b0;
			end
			CMD_TICK: begin
				if (!halted_q) begin
					if (mode_q == LINK_CONNECTING && !wait_done) begin
						wait_d = wait_sum[WAIT_W-1:0];
					end else begin
						wait_d = '0;
					end
					if (mode_q == LINK_CONNECTED && !ping_bad) begin
						ping_d = now_t;
						if (pong_q == '0) begin
							pong_d = now_t;
						end
						count_d = '0;
					end
					mode_d = mode_mid;
					if (reopen_zone) begin
						if (limit_hit) begin
							halted_d = 1'b1;
						end else begin
							count_d = count_q + 8'd1;
						end
					end
				end
			end
			CMD_CONNECTED: begin
				mode_d = LINK_CONNECTED;
				ping_d = '0;
				pong_d = '0;
			end
			CMD_DISCONNECTED: mode_d = LINK_DOWN;
			CMD_ERROR: mode_d = LINK_DOWN;
			CMD_SOCKET: begin
				case (sock_c)
					SOCK_UNCONNECTED: mode_d = LINK_DOWN;
					SOCK_CONNECTING: mode_d = LINK_CONNECTING;
					SOCK_CONNECTED: mode_d = LINK_CONNECTED;
					default: mode_d = mode_q;
				endcase
			end
			CMD_PONG: pong_d = now_t;
			default: ;
		endcase
	end

	// result fields
	logic res_reopen, res_ping, res_gave_up;
	logic res_opened, res_closed, res_error, res_changed;
	logic [7:0] res_err;
	logic [COST_W-1:0] res_cost;

	always_comb begin
		res_reopen = 1'b0;
		res_ping = 1'b0;
		res_gave_up = 1'b0;
		res_opened = 1'b0;
		res_closed = 1'b0;
		res_error = 1'b0;
		res_changed = 1'b0;
		res_err = '0;
		res_cost = '0;
		case (cmd_c)
			CMD_TICK: begin
				if (!halted_q) begin
					if (mode_q == LINK_CONNECTED) begin
						res_cost = cost_val;
						res_ping = !ping_bad;
					end
					if (reopen_zone) begin
						res_gave_up = limit_hit;
						res_reopen = !limit_hit;
					end
				end
			end
			CMD_CONNECTED: res_opened = 1'b1;
			CMD_DISCONNECTED: res_closed = 1'b1;
			CMD_ERROR: begin
				res_error = 1'b1;
				res_err = err_s1;
			end
			CMD_SOCKET: res_changed = mode_d != mode_q;
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			link_state <= mode_d;
			reopen_link <= res_reopen;
			send_ping <= res_ping;
			gave_up <= res_gave_up;
			opened_notice <= res_opened;
			closed_notice <= res_closed;
			error_notice <= res_error;
			error_out <= res_err;
			state_changed <= res_changed;
			ping_cost <= res_cost;
		end
	end

endmodule

[src/lks_checker.sv]
module lks_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] link_state,
	input logic reopen_link,
	input logic send_ping,
	input logic gave_up,
	input logic opened_notice,
	input logic closed_notice,
	input logic error_notice,
	input logic [7:0] error_out,
	input logic state_changed
);
	import lks_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(link_state) && $stable(gave_up))
		else $error("stalled result changed");

	// a ping goes out only on a healthy connected link
	a_ping_connected: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && send_ping |->
			link_state == LINK_CONNECTED && !reopen_link && !gave_up)
		else $error("ping request outside connected link");

	// reopen and give up exclude each other
	a_reopen_gave_up: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(reopen_link && gave_up))
		else $error("reopen and give up together");

	// one socket notice per request, and the error number only with its notice
	a_notices: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({opened_notice, closed_notice, error_notice, state_changed})
			&& (error_notice || error_out == 8'd0))
		else $error("notice flags inconsistent");

	// open, close and error notices report the matching link state
	a_notice_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (opened_notice || closed_notice || error_notice) |->
			(opened_notice && link_state == LINK_CONNECTED)
			|| (!opened_notice && link_state == LINK_DOWN))
		else $error("notice with wrong link state");

endmodule

bind link_keepalive_reconnect_supervisor lks_checker u_lks_checker (.*);

[tb/testbench.sv]
module testbench;
	import lks_pkg::*;

	typedef struct {
		logic [2:0] cmd;
		logic [31:0] now;
		logic [1:0] sock;
		logic [7:0] err;
	} link_req_t;

	typedef struct {
		logic [1:0] link_state;
		logic reopen_link;
		logic send_ping;
		logic gave_up;
		logic opened_notice;
		logic closed_notice;
		logic error_notice;
		logic [7:0] error_out;
		logic state_changed;
		logic signed [31:0] ping_cost;
	} link_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] cmd = '0;
	logic [31:0] now_seconds = '0;
	logic [1:0] socket_state = '0;
	logic [7:0] error_code = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] link_state;
	logic reopen_link;
	logic send_ping;
	logic gave_up;
	logic opened_notice;
	logic closed_notice;
	logic error_notice;
	logic [7:0] error_out;
	logic state_changed;
	logic signed [31:0] ping_cost;

	link_keepalive_reconnect_supervisor u_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#400000;
		$display("TEST FAILED");
		$finish;
	end

	link_req_t pending_reqs[$];
	link_result_t link_expect[$];
	link_req_t bus_req;
	bit no_idle = 1'b0;
	int fail_count = 0;

	// shadow copy of the supervisor state and registers
	logic [HB_W-1:0] cfg_hb = HB_RESET;
	logic [LIMIT_W-1:0] cfg_limit = LIMIT_RESET;
	link_mode_t lnk_mode = LINK_READY;
	logic [WAIT_W-1:0] conn_wait = '0;
	logic [7:0] reopen_cnt = '0;
	logic [31:0] ping_time = '0;
	logic [31:0] pong_time = '0;
	logic ticks_halted = 1'b1;

	task automatic predict_link(input link_req_t r);
		link_result_t res;
		logic [WAIT_W:0] wsum;
		logic [31:0] mag;
		logic neg;
		link_mode_t prev;
		res = '{default: '0};
		case (r.cmd)
			CMD_START: begin
				reopen_cnt = '0;
				lnk_mode = LINK_READY;
				ping_time = '0;
				pong_time = '0;
				ticks_halted = 1'b0;
			end
			CMD_TICK: begin
				if (!ticks_halted) begin
					if (lnk_mode == LINK_CONNECTING) begin
						wsum = {1'b0, conn_wait} + (WAIT_W+1)'(cfg_hb);
						if (wsum >= ((WAIT_W+1)'(cfg_hb) << 1)) begin
							lnk_mode = LINK_DOWN;
							conn_wait = '0;
						end else begin
							conn_wait = wsum[WAIT_W-1:0];
						end
					end else begin
						conn_wait = '0;
					end
					if (lnk_mode == LINK_CONNECTED) begin
						// pong minus ping, saturated to signed 32 bits
						if (pong_time >= ping_time) begin
							neg = 1'b0;
							mag = pong_time - ping_time;
							res.ping_cost = mag[31] ? 32'sh7FFFFFFF : mag;
						end else begin
							neg = 1'b1;
							mag = ping_time - pong_time;
							res.ping_cost = mag[31] ? 32'sh80000000 : -mag;
						end
						if (neg || mag > 32'(cfg_hb)) begin
							lnk_mode = LINK_DOWN;
						end else begin
							ping_time = r.now;
							if (pong_time == '0)
								pong_time = r.now;
							res.send_ping = 1'b1;
							reopen_cnt = '0;
						end
					end
					if (lnk_mode == LINK_READY || lnk_mode == LINK_DOWN) begin
						if (reopen_cnt >= cfg_limit) begin
							ticks_halted = 1'b1;
							res.gave_up = 1'b1;
						end else begin
							res.reopen_link = 1'b1;
							reopen_cnt = reopen_cnt + 8'd1;
						end
					end
				end
			end
			CMD_CONNECTED: begin
				lnk_mode = LINK_CONNECTED;
				ping_time = '0;
				pong_time = '0;
				res.opened_notice = 1'b1;
			end
			CMD_DISCONNECTED: begin
				lnk_mode = LINK_DOWN;
				res.closed_notice = 1'b1;
			end
			CMD_ERROR: begin
				lnk_mode = LINK_DOWN;
				res.error_notice = 1'b1;
				res.error_out = r.err;
			end
			CMD_SOCKET: begin
				prev = lnk_mode;
				case (r.sock)
					SOCK_UNCONNECTED: lnk_mode = LINK_DOWN;
					SOCK_CONNECTING: lnk_mode = LINK_CONNECTING;
					SOCK_CONNECTED: lnk_mode = LINK_CONNECTED;
					default: ;
				endcase
				res.state_changed = (lnk_mode != prev);
			end
			CMD_PONG: pong_time = r.now;
			default: ;
		endcase
		res.link_state = lnk_mode;
		link_expect.push_back(res);
	endtask

	always @(posedge clk) begin
		bit go;
		go = no_idle || ($urandom_range(99) >= 33);
		if (in_valid && in_ready)
			predict_link(bus_req);
		if (!in_valid || in_ready) begin
			if (pending_reqs.size() > 0 && go) begin
				bus_req = pending_reqs.pop_front();
				cmd <= bus_req.cmd;
				now_seconds <= bus_req.now;
				socket_state <= bus_req.sock;
				error_code <= bus_req.err;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		link_result_t want;
		if (out_valid && out_ready) begin
			if (link_expect.size() == 0) begin
				$display("%0t: result with no request pending, expected none, actual state %0d",
					$time, link_state);
				fail_count++;
			end else begin
				want = link_expect.pop_front();
				check_field("link_state", want.link_state, link_state);
				check_field("reopen_link", want.reopen_link, reopen_link);
				check_field("send_ping", want.send_ping, send_ping);
				check_field("gave_up", want.gave_up, gave_up);
				check_field("opened_notice", want.opened_notice, opened_notice);
				check_field("closed_notice", want.closed_notice, closed_notice);
				check_field("error_notice", want.error_notice, error_notice);
				check_field("error_out", want.error_out, error_out);
				check_field("state_changed", want.state_changed, state_changed);
				check_field("ping_cost", want.ping_cost, ping_cost);
			end
		end
		out_ready <= no_idle || ($urandom_range(99) >= 33);
	end

	task automatic add_req(input logic [2:0] c, input logic [31:0] t, input logic [1:0] s,
			input logic [7:0] e);
		link_req_t r;
		r.cmd = c;
		r.now = t;
		r.sock = s;
		r.err = e;
		pending_reqs.push_back(r);
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		logic [HB_W-1:0] hb_list[6];
		logic [LIMIT_W-1:0] lim_list[6];
		logic [31:0] wall;
		logic [31:0] ping_at;
		int sel;
		int count;
		hb_list = '{HB_RESET, 12'd1, 12'd4095, 12'd0, 12'd0, 12'd0};
		lim_list = '{LIMIT_RESET, 8'd0, 8'd255, 8'd1, 8'd0, 8'd0};
		for (int i = 4; i < 6; i++) begin
			hb_list[i] = HB_W'($urandom_range(1, 3600));
			lim_list[i] = LIMIT_W'($urandom_range(0, 8));
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed pass at reset settings
		add_req(CMD_TICK, 32'd0, 2'd0, 8'd0);
		add_req(3'd7, 32'hFFFFFFFF, 2'd3, 8'hFF);
		add_req(CMD_START, 32'd0, 2'd0, 8'd0);
		add_req(CMD_SOCKET, 32'd0, SOCK_CONNECTING, 8'd0);
		add_req(CMD_TICK, 32'd0, 2'd0, 8'd0);
		add_req(CMD_TICK, 32'd10, 2'd0, 8'd0);
		add_req(CMD_SOCKET, 32'd0, SOCK_OTHER, 8'd0);
		add_req(CMD_SOCKET, 32'd0, SOCK_CONNECTED, 8'd0);
		add_req(CMD_CONNECTED, 32'd0, 2'd0, 8'd0);
		add_req(CMD_PONG, 32'hFFFFFFFF, 2'd0, 8'd0);
		add_req(CMD_TICK, 32'd0, 2'd0, 8'd0);
		add_req(CMD_CONNECTED, 32'd0, 2'd0, 8'd0);
		add_req(CMD_TICK, 32'hFFFFFFF0, 2'd0, 8'd0);
		add_req(CMD_PONG, 32'd5, 2'd0, 8'd0);
		add_req(CMD_TICK, 32'd20, 2'd0, 8'd0);
		add_req(CMD_ERROR, 32'd0, 2'd0, 8'hFF);
		add_req(CMD_ERROR, 32'd0, 2'd0, 8'h00);
		add_req(CMD_DISCONNECTED, 32'd0, 2'd0, 8'd0);
		add_req(CMD_SOCKET, 32'd0, SOCK_UNCONNECTED, 8'd0);
		repeat (4) add_req(CMD_TICK, 32'd30, 2'd0, 8'd0);
		add_req(CMD_START, 32'd0, 2'd0, 8'd0);

		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0) begin
				do @(negedge clk); while (pending_reqs.size() || in_valid || link_expect.size());
				repeat (4) @(posedge clk);
				cfg_write(REG_HEARTBEAT, 32'(hb_list[ph]));
				cfg_write(REG_LIMIT, 32'(lim_list[ph]));
				cfg_hb = hb_list[ph];
				cfg_limit = lim_list[ph];
			end
			no_idle = (ph == 4);
			wall = $urandom;
			count = 0;
			while (count < 170) begin
				if ($urandom_range(99) < 60) begin
					// well-formed session: start, optional connect wait, pings, drop, reopens
					add_req(CMD_START, wall, 2'($urandom_range(3)), 8'($urandom_range(255)));
					count++;
					if ($urandom_range(1)) begin
						add_req(CMD_SOCKET, wall, SOCK_CONNECTING, 8'($urandom_range(255)));
						count++;
						repeat ($urandom_range(3)) begin
							wall += 32'(cfg_hb);
							add_req(CMD_TICK, wall, 2'($urandom_range(3)),
								8'($urandom_range(255)));
							count++;
						end
					end
					if ($urandom_range(1))
						add_req(CMD_CONNECTED, wall, 2'($urandom_range(3)),
							8'($urandom_range(255)));
					else
						add_req(CMD_SOCKET, wall, SOCK_CONNECTED, 8'($urandom_range(255)));
					count++;
					repeat ($urandom_range(1, 6)) begin
						wall += 32'(cfg_hb);
						ping_at = wall;
						add_req(CMD_TICK, wall, 2'($urandom_range(3)), 8'($urandom_range(255)));
						count++;
						sel = $urandom_range(99);
						if (sel < 90) begin
							if (sel < 70)
								ping_at += $urandom_range(cfg_hb);
							else if (sel < 80)
								ping_at += 32'(cfg_hb) + $urandom_range(1, 1000);
							else
								ping_at -= $urandom_range(1, 1000);
							add_req(CMD_PONG, ping_at, 2'($urandom_range(3)),
								8'($urandom_range(255)));
							count++;
						end
					end
					wall += 32'(cfg_hb);
					add_req(CMD_TICK, wall, 2'($urandom_range(3)), 8'($urandom_range(255)));
					sel = $urandom_range(2);
					if (sel == 0)
						add_req(CMD_DISCONNECTED, wall, 2'($urandom_range(3)),
							8'($urandom_range(255)));
					else if (sel == 1)
						add_req(CMD_ERROR, wall, 2'($urandom_range(3)),
							8'($urandom_range(255)));
					else
						add_req(CMD_SOCKET, wall, SOCK_UNCONNECTED, 8'($urandom_range(255)));
					count += 2;
					repeat ($urandom_range(1, 8)) begin
						wall += 32'(cfg_hb);
						add_req(CMD_TICK, wall, 2'($urandom_range(3)), 8'($urandom_range(255)));
						count++;
					end
				end else begin
					repeat ($urandom_range(1, 8)) begin
						add_req(3'($urandom_range(7)),
							$urandom_range(1) ? $urandom : wall + $urandom_range(cfg_hb),
							2'($urandom_range(3)), 8'($urandom_range(255)));
						count++;
					end
				end
			end
		end

		do @(negedge clk); while (pending_reqs.size() || in_valid || link_expect.size());
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
